/* src/gcmb_pkg.sv */
// ----------------------------------------------------------------------------
// gcmb_pkg
// shared types and constants for the grid center-of-mass binner
// ----------------------------------------------------------------------------
package gcmb_pkg;

  localparam int GRID_BITS_DEF     = 5;
  localparam int SPECIES_COUNT_DEF = 2;

  localparam int POS_W   = 24;
  localparam int VEL_W   = 24;
  localparam int EN_W    = 24;
  localparam int PM_W    = 24;
  localparam int RECIP_W = 32;
  localparam int MASS_W  = 48;
  localparam int MOM_W   = 64;
  localparam int ID_W    = 16;
  localparam int KIND_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 32;

  // multiplier operand widths: signed 25 by signed 33
  localparam int MA_W = 25;
  localparam int MB_W = 33;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRAIN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CIDX_W-1:0] REG_BOX_RECIP = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MASS_GAS  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MASS_DARK = 2'd2;

  localparam logic [RECIP_W-1:0] BOX_RECIP_RST = 32'd256;

  localparam logic [23:0] U24_MAX = 24'hFFFFFF;
  localparam logic [23:0] S24_MAX = 24'h7FFFFF;
  localparam logic [23:0] S24_MIN = 24'h800000;

  typedef struct packed {
    logic              start;
    logic [MOM_W-1:0]  dividend;
    logic [MASS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MOM_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* src/gcmb_if.sv */
// ----------------------------------------------------------------------------
// gcmb channel interfaces
// input, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface gcmb_in_if import gcmb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic                     species;
  logic [POS_W-1:0]         pos_x;
  logic [POS_W-1:0]         pos_y;
  logic [POS_W-1:0]         pos_z;
  logic signed [VEL_W-1:0]  vel_x;
  logic signed [VEL_W-1:0]  vel_y;
  logic signed [VEL_W-1:0]  vel_z;
  logic [EN_W-1:0]          energy;
  logic [PM_W-1:0]          particle_mass;
  modport source (output valid, kind, species, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  energy, particle_mass, input ready);
  modport sink (input valid, kind, species, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                energy, particle_mass, output ready);
endinterface

interface gcmb_out_if import gcmb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     out_species;
  logic [ID_W-1:0]          cell_id;
  logic [MASS_W-1:0]        total_mass;
  logic [POS_W-1:0]         mean_pos_x;
  logic [POS_W-1:0]         mean_pos_y;
  logic [POS_W-1:0]         mean_pos_z;
  logic signed [VEL_W-1:0]  mean_vel_x;
  logic signed [VEL_W-1:0]  mean_vel_y;
  logic signed [VEL_W-1:0]  mean_vel_z;
  logic [EN_W-1:0]          mean_energy;
  logic                     done_res;
  modport source (output valid, out_species, cell_id, total_mass, mean_pos_x, mean_pos_y,
                  mean_pos_z, mean_vel_x, mean_vel_y, mean_vel_z, mean_energy, done_res,
                  input ready);
  modport sink (input valid, out_species, cell_id, total_mass, mean_pos_x, mean_pos_y,
                mean_pos_z, mean_vel_x, mean_vel_y, mean_vel_z, mean_energy, done_res,
                output ready);
endinterface

interface gcmb_cfg_if import gcmb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/grid_center_of_mass_binner.sv */
// ----------------------------------------------------------------------------
// grid_center_of_mass_binner
// nearest-grid-point mass deposit with per-cell mass-weighted moments
// ----------------------------------------------------------------------------
// One beat at a time. A load beat runs three position by box_recip
// products for the cell index, a read of the cell, seven moment products
// each followed by a saturating add, and a write back, all through one
// shared 25x33 multiplier. A drain beat scans the cell memory, passing
// each empty cell through read, wait and check states, then runs seven
// 64-bit divisions through one restoring divider at one bit per cycle
// for each emitted cell; a drain past the last occupied cell returns the
// done beat. After reset and after every clear beat the cell memories are
// zeroed by a pass over SPECIES_COUNT * 2^(3*GRID_BITS) entries (65536 at
// the defaults) during which no input beat is taken; configuration writes
// are taken at any time. Results sit in an output register, so the next
// beat can be accepted while a result waits.
// ----------------------------------------------------------------------------
module grid_center_of_mass_binner import gcmb_pkg::*; #(
  parameter int GRID_BITS     = GRID_BITS_DEF,
  parameter int SPECIES_COUNT = SPECIES_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gcmb_in_if.sink    in_ch,
  gcmb_out_if.source out_ch,
  gcmb_cfg_if.sink   cfg
);

  localparam int CELL_BITS = 3 * GRID_BITS;
  localparam int CELLS     = 1 << CELL_BITS;
  localparam int SP_BITS   = (SPECIES_COUNT > 1) ? 1 : 0;
  localparam int AW        = CELL_BITS + SP_BITS;
  localparam int DEPTH     = SPECIES_COUNT * CELLS;
  localparam int SHIFT     = RECIP_W - GRID_BITS;
  localparam int HI_W      = POS_W + RECIP_W - SHIFT;
  localparam int WORD_W    = MASS_W + 6 * MOM_W;
  localparam logic [HI_W-1:0] AXIS_MAX = HI_W'((1 << GRID_BITS) - 1);
  localparam logic [AW:0]     SCAN_END = (AW + 1)'(DEPTH);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_MUL      = 13'b0000000000100,
    S_ACC      = 13'b0000000001000,
    S_RD       = 13'b0000000010000,
    S_LATCH    = 13'b0000000100000,
    S_WR       = 13'b0000001000000,
    S_SCAN_RD  = 13'b0000010000000,
    S_SCAN_W   = 13'b0000100000000,
    S_SCAN_CHK = 13'b0001000000000,
    S_DIV      = 13'b0010000000000,
    S_DIVW     = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [RECIP_W-1:0] box_recip;
  logic [PM_W-1:0]    fixed_mass_gas;
  logic [PM_W-1:0]    fixed_mass_dark;

  // latched load item
  logic                    it_sp;
  logic [POS_W-1:0]        it_pos [3];
  logic signed [VEL_W-1:0] it_vel [3];
  logic [EN_W-1:0]         it_energy;
  logic [PM_W-1:0]         it_mass;

  // working copy of one cell
  logic [MASS_W-1:0] wk_mass;
  logic [MOM_W-1:0]  wk_mom [7];
  logic [GRID_BITS-1:0] ax_cell [2];

  logic [3:0]     step;
  logic [2:0]     k;
  logic [AW-1:0]  addr;
  logic [AW-1:0]  clr_ptr;
  logic [AW:0]    scan_ptr;
  logic           cur_sp;
  logic [ID_W-1:0] emit_cnt [2];
  logic [EN_W-1:0] mean [7];
  logic           done_flag;

  // memories
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic              en_we;
  logic [MOM_W-1:0]  en_wdata;
  logic [MOM_W-1:0]  en_rdata;

  // shared units
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // mass of the incoming particle: species register unless it is zero
  logic [PM_W-1:0] in_fixed;
  logic [PM_W-1:0] in_mass;
  logic            in_sp_ok;

  // accumulate path
  logic [1:0]          acc_axis;
  logic [HI_W-1:0]     idx_hi;
  logic [GRID_BITS-1:0] idx_cell;
  logic [MOM_W-1:0]    acc_old;
  logic [MOM_W:0]      usum;
  logic [MOM_W:0]      ssum;
  logic [MOM_W-1:0]    uacc;
  logic [MOM_W-1:0]    sacc;
  logic [MASS_W:0]     msum;
  logic [CELL_BITS-1:0] new_cell;

  // divide path
  logic [MOM_W-1:0] div_src;
  logic             div_neg;
  logic [MOM_W-1:0] q;
  logic [MOM_W-1:0] q_neg;
  logic [EN_W-1:0]  q_mean;

  logic in_acc;
  logic out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  assign in_fixed = in_ch.species ? fixed_mass_dark : fixed_mass_gas;
  assign in_mass  = (in_fixed != '0) ? in_fixed : in_ch.particle_mass;
  assign in_sp_ok = {1'b0, in_ch.species} < 2'(SPECIES_COUNT);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      box_recip       <= BOX_RECIP_RST;
      fixed_mass_gas  <= '0;
      fixed_mass_dark <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_BOX_RECIP: box_recip       <= cfg.data;
        REG_MASS_GAS:  fixed_mass_gas  <= cfg.data[PM_W-1:0];
        REG_MASS_DARK: fixed_mass_dark <= cfg.data[PM_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = MB_W'({1'b0, it_mass});
    unique case (step)
      4'd0: begin
        mul_a = MA_W'({1'b0, it_pos[0]});
        mul_b = MB_W'({1'b0, box_recip});
      end
      4'd1: begin
        mul_a = MA_W'({1'b0, it_pos[1]});
        mul_b = MB_W'({1'b0, box_recip});
      end
      4'd2: begin
        mul_a = MA_W'({1'b0, it_pos[2]});
        mul_b = MB_W'({1'b0, box_recip});
      end
      4'd3: mul_a = MA_W'({1'b0, it_pos[0]});
      4'd4: mul_a = MA_W'({1'b0, it_pos[1]});
      4'd5: mul_a = MA_W'({1'b0, it_pos[2]});
      4'd6: mul_a = MA_W'(it_vel[0]);
      4'd7: mul_a = MA_W'(it_vel[1]);
      4'd8: mul_a = MA_W'(it_vel[2]);
      default: mul_a = MA_W'({1'b0, it_energy});
    endcase
  end

  gcmb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // cell index from the product, clamped to the last cell
  assign idx_hi   = HI_W'(mul_p[POS_W+RECIP_W-1:0] >> SHIFT);
  assign idx_cell = (idx_hi > AXIS_MAX) ? AXIS_MAX[GRID_BITS-1:0] : idx_hi[GRID_BITS-1:0];
  assign new_cell = {ax_cell[0], ax_cell[1], idx_cell};
  assign acc_axis = step[1:0];

  // moment slot for this step: pos 0..2, vel 3..5, energy 6
  always_comb begin
    if (step >= 4'd9) begin
      k = 3'd6;
    end else if (step >= 4'd6) begin
      k = 3'(step - 4'd3);
    end else begin
      k = 3'(step - 4'd3);
    end
  end

  assign acc_old = wk_mom[k];
  assign usum    = {1'b0, acc_old} + {{(MOM_W + 1 - MP_W){1'b0}}, mul_p};
  assign ssum    = {acc_old[MOM_W-1], acc_old} + (MOM_W + 1)'(mul_p);
  assign uacc    = usum[MOM_W] ? {MOM_W{1'b1}} : usum[MOM_W-1:0];
  always_comb begin
    if (ssum[MOM_W] != ssum[MOM_W-1]) begin
      sacc = ssum[MOM_W] ? {1'b1, {(MOM_W - 1){1'b0}}} : {1'b0, {(MOM_W - 1){1'b1}}};
    end else begin
      sacc = ssum[MOM_W-1:0];
    end
  end

  assign msum = {1'b0, ram_rdata[WORD_W-1 -: MASS_W]} + (MASS_W + 1)'(it_mass);

  // divider feed: velocity moments go in as magnitudes
  assign div_src = wk_mom[step[2:0]];
  assign div_neg = (step[2:0] >= 3'd3) && (step[2:0] <= 3'd5) && div_src[MOM_W-1];

  always_comb begin
    div_req.start    = (state == S_DIV);
    div_req.dividend = div_neg ? (~div_src + 1'b1) : div_src;
    div_req.divisor  = wk_mass;
  end

  gcmb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // clamp the quotient to its field; the energy mean is zero for the dark species
  assign q     = div_rsp.quotient;
  assign q_neg = ~q + 1'b1;
  always_comb begin
    if ((step[2:0] >= 3'd3) && (step[2:0] <= 3'd5)) begin
      if (div_neg) begin
        q_mean = (q > MOM_W'(S24_MIN)) ? S24_MIN : q_neg[EN_W-1:0];
      end else begin
        q_mean = (q > MOM_W'(S24_MAX)) ? S24_MAX : q[EN_W-1:0];
      end
    end else if (step[2:0] == 3'd6 && cur_sp) begin
      q_mean = '0;
    end else begin
      q_mean = (q > MOM_W'(U24_MAX)) ? U24_MAX : q[EN_W-1:0];
    end
  end

  // memory ports
  assign ram_we    = (state == S_CLEAR) || (state == S_WR);
  assign ram_waddr = (state == S_CLEAR) ? clr_ptr : addr;
  assign ram_wdata = (state == S_CLEAR) ? '0 :
                     {wk_mass, wk_mom[0], wk_mom[1], wk_mom[2],
                      wk_mom[3], wk_mom[4], wk_mom[5]};
  assign en_we     = (state == S_CLEAR) || ((state == S_WR) && !it_sp);
  assign en_wdata  = (state == S_CLEAR) ? '0 : wk_mom[6];

  gcmb_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  gcmb_ram #(.WIDTH(MOM_W), .DEPTH(CELLS)) u_energy_ram (
    .clk   (clk),
    .we    (en_we),
    .waddr ((state == S_CLEAR) ? clr_ptr[CELL_BITS-1:0] : addr[CELL_BITS-1:0]),
    .wdata (en_wdata),
    .raddr (addr[CELL_BITS-1:0]),
    .rdata (en_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_ptr       <= '0;
      scan_ptr      <= '0;
      emit_cnt[0]   <= '0;
      emit_cnt[1]   <= '0;
      out_ch.valid  <= 1'b0;
    end else begin
      // output register empties on its beat unless a new result lands now
      if (out_ch.valid && out_ch.ready && (state != S_OUT)) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        // zero the cell memories one entry a cycle
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (&clr_ptr) begin
            scan_ptr    <= '0;
            emit_cnt[0] <= '0;
            emit_cnt[1] <= '0;
            state       <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            it_sp     <= in_ch.species;
            it_pos[0] <= in_ch.pos_x;
            it_pos[1] <= in_ch.pos_y;
            it_pos[2] <= in_ch.pos_z;
            it_vel[0] <= in_ch.vel_x;
            it_vel[1] <= in_ch.vel_y;
            it_vel[2] <= in_ch.vel_z;
            it_energy <= in_ch.energy;
            it_mass   <= in_mass;
            step      <= '0;
            priority if (in_ch.kind == KIND_LOAD) begin
              if (in_sp_ok) begin
                state <= S_MUL;
              end
            end else if (in_ch.kind == KIND_DRAIN) begin
              state <= S_SCAN_RD;
            end else if (in_ch.kind == KIND_CLEAR) begin
              clr_ptr <= '0;
              state   <= S_CLEAR;
            end else begin
              // unused kind: dropped
              state <= S_IDLE;
            end
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (step <= 4'd2) begin
            if (acc_axis != 2'd2) begin
              ax_cell[acc_axis[0]] <= idx_cell;
              step  <= step + 1'b1;
              state <= S_MUL;
            end else begin
              addr  <= AW'(new_cell) | AW'(AW'(it_sp) << CELL_BITS);
              step  <= step + 1'b1;
              state <= S_RD;
            end
          end else begin
            if (step >= 4'd6 && step <= 4'd8) begin
              wk_mom[k] <= sacc;
            end else begin
              wk_mom[k] <= uacc;
            end
            if (step == 4'd9) begin
              state <= S_WR;
            end else begin
              step  <= step + 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_RD: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          wk_mass   <= msum[MASS_W] ? {MASS_W{1'b1}} : msum[MASS_W-1:0];
          wk_mom[0] <= ram_rdata[5*MOM_W +: MOM_W];
          wk_mom[1] <= ram_rdata[4*MOM_W +: MOM_W];
          wk_mom[2] <= ram_rdata[3*MOM_W +: MOM_W];
          wk_mom[3] <= ram_rdata[2*MOM_W +: MOM_W];
          wk_mom[4] <= ram_rdata[1*MOM_W +: MOM_W];
          wk_mom[5] <= ram_rdata[0 +: MOM_W];
          wk_mom[6] <= en_rdata;
          state     <= S_MUL;
        end
        S_WR: begin
          state <= S_IDLE;
        end
        // walk the cells until one holds mass or the scan runs past the last cell
        S_SCAN_RD: begin
          if (scan_ptr >= SCAN_END) begin
            done_flag <= 1'b1;
            state     <= S_OUT;
          end else begin
            addr  <= scan_ptr[AW-1:0];
            state <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          scan_ptr <= scan_ptr + 1'b1;
          if (ram_rdata[WORD_W-1 -: MASS_W] == '0) begin
            state <= S_SCAN_RD;
          end else begin
            wk_mass   <= ram_rdata[WORD_W-1 -: MASS_W];
            wk_mom[0] <= ram_rdata[5*MOM_W +: MOM_W];
            wk_mom[1] <= ram_rdata[4*MOM_W +: MOM_W];
            wk_mom[2] <= ram_rdata[3*MOM_W +: MOM_W];
            wk_mom[3] <= ram_rdata[2*MOM_W +: MOM_W];
            wk_mom[4] <= ram_rdata[1*MOM_W +: MOM_W];
            wk_mom[5] <= ram_rdata[0 +: MOM_W];
            wk_mom[6] <= en_rdata;
            cur_sp    <= (SPECIES_COUNT > 1) && addr[AW-1];
            done_flag <= 1'b0;
            step      <= '0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            mean[step[2:0]] <= q_mean;
            if (step[2:0] == 3'd6) begin
              state <= S_OUT;
            end else begin
              step  <= step + 1'b1;
              state <= S_DIV;
            end
          end
        end
        // hand the result to the output register
        S_OUT: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            if (done_flag) begin
              out_ch.out_species <= 1'b0;
              out_ch.cell_id     <= '0;
              out_ch.total_mass  <= '0;
              out_ch.mean_pos_x  <= '0;
              out_ch.mean_pos_y  <= '0;
              out_ch.mean_pos_z  <= '0;
              out_ch.mean_vel_x  <= '0;
              out_ch.mean_vel_y  <= '0;
              out_ch.mean_vel_z  <= '0;
              out_ch.mean_energy <= '0;
              out_ch.done_res    <= 1'b1;
            end else begin
              out_ch.out_species <= cur_sp;
              out_ch.cell_id     <= emit_cnt[cur_sp];
              emit_cnt[cur_sp]   <= emit_cnt[cur_sp] + 1'b1;
              out_ch.total_mass  <= wk_mass;
              out_ch.mean_pos_x  <= mean[0];
              out_ch.mean_pos_y  <= mean[1];
              out_ch.mean_pos_z  <= mean[2];
              out_ch.mean_vel_x  <= mean[3];
              out_ch.mean_vel_y  <= mean[4];
              out_ch.mean_vel_z  <= mean[5];
              out_ch.mean_energy <= mean[6];
              out_ch.done_res    <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/gcmb_ram.sv */
// ----------------------------------------------------------------------------
// gcmb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gcmb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/gcmb_mul.sv */
// ----------------------------------------------------------------------------
// gcmb_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module gcmb_mul import gcmb_pkg::*; (
  input  logic                   clk,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic signed [MP_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* src/gcmb_div.sv */
// ----------------------------------------------------------------------------
// gcmb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gcmb_div import gcmb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(MOM_W + 1);

  logic [MASS_W-1:0] rem;
  logic [MOM_W-1:0]  quo;
  logic [MASS_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              fin;
  logic [MASS_W:0]   shifted;
  logic [MASS_W+1:0] diff;

  assign shifted = {rem, quo[MOM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= CNT_W'(MOM_W);
      end else if (cnt != '0) begin
        if (!diff[MASS_W+1]) begin
          rem <= diff[MASS_W-1:0];
          quo <= {quo[MOM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[MASS_W-1:0];
          quo <= {quo[MOM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          fin <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: fin, quotient: quo};

endmodule
